// ===== hdl/omtc_pkg.sv =====
package omtc_pkg;

  localparam int WORD_BITS  = 32;
  localparam int TYPE_BITS  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Request action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]           action;
    logic [5:0]           entry_index;
    logic [WORD_BITS-1:0] entry_mask;
    logic [WORD_BITS-1:0] entry_value;
    logic [TYPE_BITS-1:0] entry_type;
    logic [WORD_BITS-1:0] entry_arg_mask;
    logic [WORD_BITS-1:0] instr_word;
  } in_item_t;

  typedef struct packed {
    logic                 matched;
    logic [5:0]           match_index;
    logic                 is_target;
    logic [WORD_BITS-1:0] target_address;
    logic                 added;
    logic [7:0]           list_index;
    logic                 list_full;
  } out_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] value;
    logic [TYPE_BITS-1:0] etype;
    logic [WORD_BITS-1:0] arg_mask;
  } tbl_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic tscan;
    logic lscan;
    logic append;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_decode;
    logic tbl_hit;
    logic tbl_miss;
    logic is_target;
    logic lst_hit;
    logic lst_miss;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/omtc_ram.sv =====
module omtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/omtc_ctrl.sv =====
module omtc_ctrl
  import omtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_TBL_SCAN  = 6'b000010,
    S_TBL_CHECK = 6'b000100,
    S_LST_SCAN  = 6'b001000,
    S_APPEND    = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid && (state_r == S_IDLE);
    cmd.tscan  = (state_r == S_TBL_SCAN);
    cmd.lscan  = (state_r == S_LST_SCAN);
    cmd.append = (state_r == S_APPEND);
    cmd.finish = (state_r == S_FINISH) && stat.out_free;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.is_decode ? S_TBL_SCAN : S_FINISH;
        end
      end
      S_TBL_SCAN: begin
        if (stat.tbl_hit) begin
          state_nxt = S_TBL_CHECK;
        end else if (stat.tbl_miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_TBL_CHECK: begin
        state_nxt = stat.is_target ? S_LST_SCAN : S_FINISH;
      end
      S_LST_SCAN: begin
        if (stat.lst_hit) begin
          state_nxt = S_FINISH;
        end else if (stat.lst_miss) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/omtc_dp.sv =====
module omtc_dp
  import omtc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int LIST_DEPTH  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LCNT_W = $clog2(LIST_DEPTH + 1);

  // Configuration
  logic [TYPE_BITS-1:0] target_type_r;
  logic [6:0]           opcode_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_type_r  <= '0;
      opcode_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_TYPE:  target_type_r  <= cfg_data[TYPE_BITS-1:0];
        CFG_OPCODE_COUNT: opcode_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Table memory
  logic [31:0]  entry_idx32;
  logic         tbl_we;
  tbl_entry_t   tbl_wdata;
  tbl_entry_t   tbl_rd;
  logic         tbl_re;

  logic [TCNT_W-1:0]    scan_r, limit_r;
  logic [TIDX_W-1:0]    tcmp_r;
  logic                 tpend_r;
  logic [WORD_BITS-1:0] word_r;
  logic [31:0]          cnt32;

  assign entry_idx32        = 32'(in_item.entry_index);
  assign tbl_we             = cmd.accept && (in_item.action == ACT_LOAD) &&
                              (entry_idx32 < TABLE_DEPTH);
  assign tbl_wdata.mask     = in_item.entry_mask;
  assign tbl_wdata.value    = in_item.entry_value;
  assign tbl_wdata.etype    = in_item.entry_type;
  assign tbl_wdata.arg_mask = in_item.entry_arg_mask;
  assign tbl_re             = cmd.tscan && (scan_r < limit_r);
  assign cnt32              = 32'(opcode_count_r);

  omtc_ram #(
    .WIDTH($bits(tbl_entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_tbl_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(entry_idx32[TIDX_W-1:0]),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(scan_r[TIDX_W-1:0]),
    .rdata(tbl_rd)
  );

  logic tbl_hit;
  assign tbl_hit = tpend_r && ((word_r & tbl_rd.mask) == tbl_rd.value);

  // Target list memory
  logic [LCNT_W-1:0]    list_count_r;
  logic [LCNT_W-1:0]    lscan_r;
  logic [LIDX_W-1:0]    lcmp_r;
  logic                 lpend_r;
  logic                 lst_re;
  logic                 lst_we;
  logic                 has_room;
  logic [WORD_BITS-1:0] lst_rd;
  logic [WORD_BITS-1:0] addr_r;
  logic                 lst_hit;

  assign lst_re   = cmd.lscan && (lscan_r < list_count_r);
  assign has_room = 32'(list_count_r) < LIST_DEPTH;
  assign lst_we   = cmd.append && has_room;
  assign lst_hit  = lpend_r && (lst_rd == addr_r);

  omtc_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(LIST_DEPTH)
  ) u_lst_ram (
    .clk  (clk),
    .we   (lst_we),
    .waddr(list_count_r[LIDX_W-1:0]),
    .wdata(addr_r),
    .re   (lst_re),
    .raddr(lscan_r[LIDX_W-1:0]),
    .rdata(lst_rd)
  );

  // Result fields
  logic              matched_r, is_target_r, added_r, full_r;
  logic [TIDX_W-1:0] midx_r;
  logic [LIDX_W-1:0] lidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpend_r      <= 1'b0;
      lpend_r      <= 1'b0;
      list_count_r <= '0;
    end else begin
      if (cmd.accept) begin
        tpend_r <= 1'b0;
        lpend_r <= 1'b0;
        if (in_item.action == ACT_CLEAR) begin
          list_count_r <= '0;
        end
      end else begin
        if (cmd.tscan) begin
          tpend_r <= tbl_re;
        end
        if (cmd.lscan) begin
          lpend_r <= lst_re;
        end
        if (lst_we) begin
          list_count_r <= list_count_r + LCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r      <= in_item.instr_word;
      limit_r     <= TCNT_W'((cnt32 < TABLE_DEPTH) ? cnt32 : TABLE_DEPTH);
      scan_r      <= '0;
      lscan_r     <= '0;
      matched_r   <= 1'b0;
      midx_r      <= '0;
      is_target_r <= 1'b0;
      addr_r      <= '0;
      added_r     <= 1'b0;
      lidx_r      <= '0;
      full_r      <= 1'b0;
    end else begin
      if (cmd.tscan) begin
        tcmp_r <= scan_r[TIDX_W-1:0];
        if (tbl_re) begin
          scan_r <= scan_r + TCNT_W'(1);
        end
        if (tbl_hit) begin
          matched_r   <= 1'b1;
          midx_r      <= tcmp_r;
          is_target_r <= (tbl_rd.etype == target_type_r);
          addr_r      <= (tbl_rd.etype == target_type_r) ?
                         (word_r & tbl_rd.arg_mask) : '0;
        end
      end
      if (cmd.lscan) begin
        lcmp_r <= lscan_r[LIDX_W-1:0];
        if (lst_re) begin
          lscan_r <= lscan_r + LCNT_W'(1);
        end
        if (lst_hit) begin
          lidx_r <= lcmp_r;
        end
      end
      if (cmd.append) begin
        if (has_room) begin
          added_r <= 1'b1;
          lidx_r  <= list_count_r[LIDX_W-1:0];
        end else begin
          full_r  <= 1'b1;
        end
      end
    end
  end

  // Output register
  logic        out_valid_r;
  out_item_t   out_r;
  logic [31:0] midx32, lidx32;

  assign midx32 = 32'(midx_r);
  assign lidx32 = 32'(lidx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.matched        <= matched_r;
      out_r.match_index    <= midx32[5:0];
      out_r.is_target      <= is_target_r;
      out_r.target_address <= addr_r;
      out_r.added          <= added_r;
      out_r.list_index     <= lidx32[7:0];
      out_r.list_full      <= full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign stat.is_decode = (in_item.action == ACT_DECODE);
  assign stat.tbl_hit   = tbl_hit;
  assign stat.tbl_miss  = !tpend_r && (scan_r >= limit_r);
  assign stat.is_target = is_target_r;
  assign stat.lst_hit   = lst_hit;
  assign stat.lst_miss  = !lpend_r && (lscan_r >= list_count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// ===== hdl/opcode_match_target_collector.sv =====
// Opcode match and target collector. A load request writes one opcode table entry
// (mask, value, type, argument mask); a clear request empties the target list; a
// decode request searches the first opcode_count entries (at most the table depth)
// in order for the first one whose masked bits equal its value, and when its type
// equals target_type, collects word AND argument mask into a list of distinct
// addresses (appended when new, flagged list_full when no room is left). Every
// request returns one result. Requests are handled one at a time; a new request is
// taken as soon as the previous one has been placed in the output register, even
// while that result still waits. The table and the list are each scanned one entry
// per cycle through the single read port of their memory. Table entries must be
// loaded before a decode can reach them.
module opcode_match_target_collector
  import omtc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int LIST_DEPTH  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence the scans: table search, type check, list search, append, finish
  omtc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Hold the table, the target list, config registers and the output register
  omtc_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

// ===== bench/tb_opcode_match_target_collector.sv =====
`timescale 1ns / 100ps

module tb_opcode_match_target_collector;
  import omtc_pkg::*;

  localparam int          TOTAL_REQUESTS = 1550;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          DRAIN_CYCLES   = 400;
  localparam int          CYCLE_LIMIT    = 3_000_000;
  localparam int          TBL_DEPTH      = 64;
  localparam int          LST_DEPTH      = 256;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  typedef struct {
    bit          set_cfg;
    logic [7:0]  cfg_type;
    logic [6:0]  cfg_count;
    in_item_t    req;
    bit          known;
    out_item_t   want;
  } vector_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block: opcode table, address list and registers
  tbl_entry_t  opcode_table [TBL_DEPTH];
  logic [31:0] addr_list [LST_DEPTH];
  int          list_len;
  logic [7:0]  cur_type;
  logic [6:0]  cur_count;

  out_item_t   pending_outcomes [$];
  vector_t     directed_vectors [$];
  logic [31:0] fill_words [$];

  int  mismatches;
  int  sent;
  int  n_decodes, n_hits, n_added, n_found, n_full;
  int  cycle_count;
  bit  hold_sink;
  bit  no_idle;

  opcode_match_target_collector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the result of one request and advance the shadow state.
  function automatic out_item_t predict_lookup(input in_item_t req);
    out_item_t   r;
    int          span;
    int          hit;
    int          pos;
    int          i;
    logic [31:0] addr;
    r = '0;
    case (req.action)
      ACT_LOAD: begin
        opcode_table[req.entry_index] = tbl_entry_t'{req.entry_mask, req.entry_value,
                                                     req.entry_type, req.entry_arg_mask};
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      ACT_DECODE: begin
        n_decodes++;
        // search only as deep as the table goes, first match wins
        span = (cur_count < 7'd64) ? int'(cur_count) : TBL_DEPTH;
        hit = -1;
        for (i = 0; i < span && hit < 0; i++) begin
          if ((req.instr_word & opcode_table[i].mask) == opcode_table[i].value) hit = i;
        end
        if (hit >= 0) begin
          n_hits++;
          r.matched = 1'b1;
          r.match_index = 6'(hit);
          if (opcode_table[hit].etype == cur_type) begin
            addr = req.instr_word & opcode_table[hit].arg_mask;
            r.is_target = 1'b1;
            r.target_address = addr;
            pos = -1;
            for (i = 0; i < list_len && pos < 0; i++) begin
              if (addr_list[i] == addr) pos = i;
            end
            if (pos >= 0) begin
              n_found++;
              r.list_index = 8'(pos);
            end else if (list_len < LST_DEPTH) begin
              n_added++;
              addr_list[list_len] = addr;
              r.added = 1'b1;
              r.list_index = 8'(list_len);
              list_len++;
            end else begin
              n_full++;
              r.list_full = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic out_item_t result_of(input logic m, input logic [5:0] idx,
                                          input logic tgt, input logic [31:0] addr,
                                          input logic add, input logic [7:0] lidx,
                                          input logic full);
    out_item_t r;
    r.matched        = m;
    r.match_index    = idx;
    r.is_target      = tgt;
    r.target_address = addr;
    r.added          = add;
    r.list_index     = lidx;
    r.list_full      = full;
    return r;
  endfunction

  // Fill every field with noise; callers then set what the action uses.
  function automatic in_item_t junk_request();
    in_item_t req;
    req.action         = 2'($urandom);
    req.entry_index    = 6'($urandom);
    req.entry_mask     = $urandom;
    req.entry_value    = $urandom;
    req.entry_type     = 8'($urandom);
    req.entry_arg_mask = $urandom;
    req.instr_word     = $urandom;
    return req;
  endfunction

  function automatic in_item_t load_req(input logic [5:0] idx, input tbl_entry_t ent);
    in_item_t req;
    req = junk_request();
    req.action         = ACT_LOAD;
    req.entry_index    = idx;
    req.entry_mask     = ent.mask;
    req.entry_value    = ent.value;
    req.entry_type     = ent.etype;
    req.entry_arg_mask = ent.arg_mask;
    return req;
  endfunction

  function automatic in_item_t decode_req(input logic [31:0] word);
    in_item_t req;
    req = junk_request();
    req.action     = ACT_DECODE;
    req.instr_word = word;
    return req;
  endfunction

  function automatic in_item_t plain_req(input logic [1:0] action);
    in_item_t req;
    req = junk_request();
    req.action = action;
    return req;
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'hA5;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly matchable entries; some with value bits outside the mask, which never hit.
  function automatic tbl_entry_t random_entry();
    tbl_entry_t ent;
    case ($urandom_range(19))
      0: ent.mask = '0;
      1, 2, 3: ent.mask = '1;
      4, 5, 6: ent.mask = 32'hFF00_0000;
      7, 8: ent.mask = 32'hF000_000F;
      default: ent.mask = $urandom;
    endcase
    ent.value = ($urandom_range(99) < 85) ? ($urandom & ent.mask) : $urandom;
    ent.etype = $urandom_range(1) ? cur_type : pick_type();
    case ($urandom_range(4))
      0: ent.arg_mask = 32'h0000_000F;
      1: ent.arg_mask = 32'h0000_00FF;
      2: ent.arg_mask = 32'h0000_3FFF;
      3: ent.arg_mask = '1;
      default: ent.arg_mask = $urandom;
    endcase
    return ent;
  endfunction

  // Mix of requests; most decodes are aimed at a searched entry.
  function automatic in_item_t random_request();
    in_item_t   req;
    tbl_entry_t ent;
    int         roll;
    int         span;
    roll = $urandom_range(99);
    span = (cur_count < 7'd64) ? int'(cur_count) : TBL_DEPTH;
    if (roll < 10) begin
      req = load_req(6'($urandom), random_entry());
    end else if (roll < 14) begin
      req = plain_req(ACT_CLEAR);
    end else if (roll < 16) begin
      req = plain_req(ACT_UNUSED);
    end else begin
      req = decode_req($urandom);
      if (span > 0 && roll < 80) begin
        ent = opcode_table[$urandom_range(span - 1)];
        req.instr_word = ($urandom & ~ent.mask) | (ent.value & ent.mask);
      end
    end
    return req;
  endfunction

  function automatic void add_vector(input bit set_cfg, input logic [7:0] ttype,
                                     input logic [6:0] tcount, input in_item_t req,
                                     input bit known, input out_item_t want);
    directed_vectors.push_back('{set_cfg, ttype, tcount, req, known, want});
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch("result with no request pending", got.target_address, 32'd0);
    end else begin
      want = pending_outcomes.pop_front();
      if (got.matched !== want.matched)
        report_mismatch("matched", 32'(got.matched), 32'(want.matched));
      if (got.match_index !== want.match_index)
        report_mismatch("match_index", 32'(got.match_index), 32'(want.match_index));
      if (got.is_target !== want.is_target)
        report_mismatch("is_target", 32'(got.is_target), 32'(want.is_target));
      if (got.target_address !== want.target_address)
        report_mismatch("target_address", got.target_address, want.target_address);
      if (got.added !== want.added)
        report_mismatch("added", 32'(got.added), 32'(want.added));
      if (got.list_index !== want.list_index)
        report_mismatch("list_index", 32'(got.list_index), 32'(want.list_index));
      if (got.list_full !== want.list_full)
        report_mismatch("list_full", 32'(got.list_full), 32'(want.list_full));
    end
  endtask

  // Offer one request and hold it until accepted; return at the accepting edge.
  // The predictor runs at acceptance so the shadow state follows the block's order.
  task automatic offer_request(input in_item_t req, input bit known, input out_item_t want);
    out_item_t predicted;
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_lookup(req);
    pending_outcomes.push_back(known ? want : predicted);
    sent++;
  endtask

  // Drop valid and wait until every pending result is back: the block is idle then.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; keep the write enable high between them.
  task automatic write_config(input logic [7:0] ttype, input logic [6:0] tcount);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_TYPE;
    cfg_data  <= ttype;
    @(posedge clk);
    cfg_index <= CFG_OPCODE_COUNT;
    cfg_data  <= {1'b0, tcount};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_type  = ttype;
    cur_count = tcount;
  endtask

  // Result side: check each accepted result, idle at random, and on request hold
  // off for a long stretch so the block backs up into its input.
  initial begin : result_sink
    int stall_cycles;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result(out_item);
      if (hold_sink) begin
        out_ready <= 1'b0;
        for (stall_cycles = 0; stall_cycles < HOLD_CYCLES; stall_cycles++) @(posedge clk);
        hold_sink = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 9);
    end
  end

  // Watchdog: end a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int          e;
    int          n;
    int          phase;
    logic [31:0] w;
    mismatches = 0;
    sent       = 0;
    n_decodes  = 0;
    n_hits     = 0;
    n_added    = 0;
    n_found    = 0;
    n_full     = 0;
    hold_sink  = 1'b0;
    no_idle    = 1'b0;
    list_len   = 0;
    cur_type   = '0;
    cur_count  = '0;
    foreach (opcode_table[k]) opcode_table[k] = '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Registers start at zero, so nothing is searched at first.
    add_vector(0, 8'h00, 7'd0, decode_req(32'hFFFF_FFFF), 1, '0);
    add_vector(0, 8'h00, 7'd0, plain_req(ACT_CLEAR), 1, '0);
    // unused action with every other bit set: must not load anything
    add_vector(0, 8'h00, 7'd0, in_item_t'('1), 1, '0);
    add_vector(0, 8'h00, 7'd0,
               load_req(6'd0, tbl_entry_t'{32'hFFFF_FFFF, 32'hDEAD_BEEF, 8'hA5, 32'hFFFF_FFFF}),
               1, '0);
    add_vector(0, 8'h00, 7'd0,
               load_req(6'd1, tbl_entry_t'{32'hFF00_0000, 32'h1200_0000, 8'hA5, 32'h0000_FFFF}),
               1, '0);
    add_vector(0, 8'h00, 7'd0,
               load_req(6'd2, tbl_entry_t'{32'hFF00_0000, 32'h3400_0000, 8'h00, 32'h00FF_FFFF}),
               1, '0);
    // catch-all entry
    add_vector(0, 8'h00, 7'd0,
               load_req(6'd3, tbl_entry_t'{32'h0, 32'h0, 8'hFF, 32'hFFFF_FFFF}), 1, '0);
    add_vector(0, 8'h00, 7'd0,
               load_req(6'd63, tbl_entry_t'{32'hFFFF_FFFF, 32'h0, 8'hA5, 32'hFFFF_FFFF}), 1, '0);
    add_vector(1, 8'hA5, 7'd4, decode_req(32'hDEAD_BEEF), 1,
               result_of(1, 6'd0, 1, 32'hDEAD_BEEF, 1, 8'd0, 0));
    add_vector(0, 8'hA5, 7'd4, decode_req(32'h1200_0042), 1,
               result_of(1, 6'd1, 1, 32'h0000_0042, 1, 8'd1, 0));
    // same address again: found, not appended
    add_vector(0, 8'hA5, 7'd4, decode_req(32'h1299_0042), 1,
               result_of(1, 6'd1, 1, 32'h0000_0042, 0, 8'd1, 0));
    // match on an entry of another type
    add_vector(0, 8'hA5, 7'd4, decode_req(32'h3400_0001), 1,
               result_of(1, 6'd2, 0, 32'h0, 0, 8'd0, 0));
    add_vector(0, 8'hA5, 7'd4, decode_req(32'h0000_0000), 1,
               result_of(1, 6'd3, 0, 32'h0, 0, 8'd0, 0));
    add_vector(0, 8'hA5, 7'd4, plain_req(ACT_CLEAR), 1, '0);
    add_vector(0, 8'hA5, 7'd4, decode_req(32'h1200_0042), 0, '0);
    add_vector(1, 8'hFF, 7'd4, decode_req(32'h0000_0000), 0, '0);
    add_vector(0, 8'hFF, 7'd4, decode_req(32'hFFFF_FFFF), 0, '0);
    // only entry 0 searched: no match
    add_vector(1, 8'h00, 7'd1, decode_req(32'h1200_0000), 1, '0);
    // entry whose value has bits outside its mask never matches
    add_vector(0, 8'h00, 7'd1,
               load_req(6'd0, tbl_entry_t'{32'h0, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF}), 1, '0);
    add_vector(0, 8'h00, 7'd1, decode_req(32'hDEAD_BEEF), 0, '0);
    // zero address already in the list
    add_vector(1, 8'h00, 7'd3, decode_req(32'h3400_0000), 0, '0);

    foreach (directed_vectors[v]) begin
      if (directed_vectors[v].set_cfg) begin
        drain_results();
        write_config(directed_vectors[v].cfg_type, directed_vectors[v].cfg_count);
      end
      offer_request(directed_vectors[v].req, directed_vectors[v].known,
                    directed_vectors[v].want);
    end

    // Load every table entry so any count is safe to search from here on.
    drain_results();
    write_config(8'hA5, 7'd64);
    for (e = 0; e < TBL_DEPTH; e++) offer_request(load_req(6'(e), random_entry()), 1'b0, '0);

    // Fill the address list past its end with a catch-all entry and wide addresses;
    // reuse a few earlier words so deep positions are found again. Count beyond depth.
    drain_results();
    write_config(8'hFF, 7'd127);
    offer_request(plain_req(ACT_CLEAR), 1'b0, '0);
    offer_request(load_req(6'd0, tbl_entry_t'{32'h0, 32'h0, 8'hFF, 32'h0003_FFFF}), 1'b0, '0);
    for (n = 0; n < 290; n++) begin
      w = (fill_words.size() > 8 && $urandom_range(9) == 0) ?
          fill_words[$urandom_range(fill_words.size() - 1)] : $urandom;
      fill_words.push_back(w);
      offer_request(decode_req(w), 1'b0, '0);
    end
    offer_request(load_req(6'd0, random_entry()), 1'b0, '0);

    // Back pressure: hold the result side while requests keep coming.
    drain_results();
    write_config(pick_type(), 7'd64);
    hold_sink = 1'b1;
    for (n = 0; n < 40; n++) offer_request(random_request(), 1'b0, '0);

    // Random phases; each starts from an idle block with a fresh setting.
    phase = 0;
    while (sent < TOTAL_REQUESTS) begin
      drain_results();
      case (phase)
        0: write_config(8'h00, 7'd0);
        1: write_config(8'hFF, 7'd1);
        2: write_config(8'hA5, 7'd64);
        3: write_config(pick_type(), 7'd127);
        default: write_config(pick_type(), $urandom_range(1) ?
                              7'($urandom_range(1, 12)) : 7'($urandom_range(0, 127)));
      endcase
      // one long stretch with no idling on either side
      no_idle = (phase == 2);
      n = (phase == 2) ? 150 : $urandom_range(40, 120);
      while (n > 0 && sent < TOTAL_REQUESTS) begin
        offer_request(random_request(), 1'b0, '0);
        n--;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d random phases; %0d decodes, %0d matched.",
             sent, phase, n_decodes, n_hits);
    $display("Addresses: %0d appended, %0d found again, %0d dropped on a full list.",
             n_added, n_found, n_full);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
